@@ rtl/core/vbc_pkg.sv @@
// package: constants, register indexes and class codes for the volume bar classifier
package vbc_pkg;

  localparam int unsigned HistoryDepthDefault = 256;
  localparam int unsigned LowestWindowDefault = 20;

  localparam int unsigned CfgWidth     = 9;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned ProdWidth    = 64;
  localparam int unsigned QuotWidth    = 48;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned ClassWidth   = 3;

  localparam logic [CfgWidth-1:0] MaPeriodReset = 9'd100;
  localparam logic [CfgWidth-1:0] LookBackReset = 9'd20;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MA_PERIOD = 1'b0,
    REG_LOOK_BACK = 1'b1
  } reg_idx_e;

  typedef enum logic [ClassWidth-1:0] {
    CLS_NEUTRAL      = 3'd0,
    CLS_LOW          = 3'd1,
    CLS_CLIMAX_HIGH  = 3'd2,
    CLS_HIGH_CHURN   = 3'd3,
    CLS_CLIMAX_CHURN = 3'd4,
    CLS_CLIMAX_LOW   = 3'd5
  } class_e;

  typedef struct packed {
    logic [DataWidth-1:0] vol;
    logic [ProdWidth-1:0] prod;
    logic [QuotWidth-1:0] quot;
  } hist_entry_t;

endpackage

@@ rtl/core/volume_bar_classifier.sv @@
// top level: volume bar classifier with history memory, shared divider and sequencer
// One bar is taken at a time. Its result waits for a walk over the history memory that
// visits the N newest entries, where N is the largest of the clamped ma_period, look_back
// and the lowest-volume window (at most the history depth), and for two passes of the
// shared 48-step restoring divider, one for the bar's volume/range quotient and one for
// the volume average; a shown result may then wait on out_stall_i. in_stall_o is high
// from acceptance until the result is taken. Entries not yet written are masked by the
// received-bar count, so the history needs no clearing pass after reset.
module volume_bar_classifier #(
  parameter int unsigned HISTORY_DEPTH = vbc_pkg::HistoryDepthDefault,
  parameter int unsigned LOWEST_WINDOW = vbc_pkg::LowestWindowDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [vbc_pkg::DataWidth-1:0]       bar_volume_i,
  input  logic [vbc_pkg::DataWidth-1:0]       high_price_i,
  input  logic [vbc_pkg::DataWidth-1:0]       low_price_i,
  input  logic [vbc_pkg::DataWidth-1:0]       close_price_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [vbc_pkg::ClassWidth-1:0]      bar_class_o,
  output logic [vbc_pkg::DataWidth-1:0]       class_volume_o,
  output logic [vbc_pkg::DataWidth-1:0]       average_volume_o,
  input  logic                                cfg_we_i,
  input  logic [vbc_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [vbc_pkg::CfgWidth-1:0]        cfg_data_i
);
  import vbc_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned WW = (CW > CfgWidth) ? CW : CfgWidth;
  localparam int unsigned SW = DataWidth + CW;
  localparam int unsigned LN = (LOWEST_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : LOWEST_WINDOW;
  localparam int unsigned DivSteps = QuotWidth;
  localparam int unsigned DCW = $clog2(DivSteps);
  localparam logic [CW-1:0] DepthC = CW'(HISTORY_DEPTH);
  localparam logic [CW-1:0] LowN = CW'(LN);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIVQ, ST_WRITE, ST_READ, ST_ACC, ST_SETUP, ST_DIVA, ST_DONE
  } state_e;

  state_e state_q;
  logic [CfgWidth-1:0] ma_q, lb_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] bars_q, k_q;
  logic [DataWidth-1:0] vol_q, hi_q, lo_q, cl_q, range_q, rem_q, dsr_q;
  logic [ProdWidth-1:0] prod_q, maxp_q;
  logic [QuotWidth-1:0] quot_q, maxq_q, dvd_q;
  logic [DataWidth-1:0] lowest_q;
  logic [SW-1:0] sum_q;
  logic [DCW-1:0] cnt_q;
  logic out_valid_q;
  logic [ClassWidth-1:0] class_q;
  logic [DataWidth-1:0] avg_q;

  hist_entry_t mem [HISTORY_DEPTH];
  hist_entry_t rd_q;

  logic [CW-1:0] n_ma, n_lb, n_walk, addr_w;
  logic [AW-1:0] addr;
  logic [WW-1:0] ma_w, lb_w;
  logic [DataWidth:0] trial;
  logic ge;
  logic [DataWidth-1:0] rem_d;
  logic [QuotWidth-1:0] dvd_d, quot_w;
  logic ent_ok;
  logic [DataWidth-1:0] e_vol;
  logic [ProdWidth-1:0] e_prod;
  logic [QuotWidth-1:0] e_quot;
  logic prod_max, quot_max, close_high, is_lowest;
  class_e cls;

  // window clamping
  always_comb begin
    ma_w = WW'(ma_q);
    lb_w = WW'(lb_q);
    if (ma_w == '0) n_ma = CW'(1);
    else if (ma_w > WW'(HISTORY_DEPTH)) n_ma = DepthC;
    else n_ma = CW'(ma_w);
    if (lb_w == '0) n_lb = CW'(1);
    else if (lb_w > WW'(HISTORY_DEPTH)) n_lb = DepthC;
    else n_lb = CW'(lb_w);
    n_walk = (n_ma > n_lb) ? n_ma : n_lb;
    if (LowN > n_walk) n_walk = LowN;
  end

  // circular read address
  always_comb begin
    if (k_q <= CW'(wp_q)) addr_w = CW'(wp_q) - k_q;
    else addr_w = CW'(wp_q) + DepthC - k_q;
    addr = addr_w[AW-1:0];
  end

  // shared restoring divider step
  always_comb begin
    trial = {rem_q, dvd_q[QuotWidth-1]};
    ge = (trial >= {1'b0, dsr_q});
    rem_d = ge ? DataWidth'(trial - {1'b0, dsr_q}) : trial[DataWidth-1:0];
    dvd_d = {dvd_q[QuotWidth-2:0], ge};
    quot_w = (range_q == '0) ? '0 : dvd_q;
  end

  // history entry seen by the walk
  always_comb begin
    ent_ok = (k_q < bars_q);
    e_vol  = ent_ok ? rd_q.vol : '0;
    e_prod = ent_ok ? rd_q.prod : '0;
    e_quot = ent_ok ? rd_q.quot : '0;
  end

  // class rule
  always_comb begin
    prod_max   = (prod_q == maxp_q);
    quot_max   = (quot_q == maxq_q);
    close_high = ({cl_q, 1'b0} > ({1'b0, hi_q} + {1'b0, lo_q}));
    is_lowest  = (vol_q == lowest_q);
    if (prod_max && !close_high) cls = CLS_CLIMAX_LOW;
    else if (prod_max && quot_max) cls = CLS_CLIMAX_CHURN;
    else if (quot_max) cls = CLS_HIGH_CHURN;
    else if (prod_max) cls = CLS_CLIMAX_HIGH;
    else if (is_lowest) cls = CLS_LOW;
    else cls = CLS_NEUTRAL;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      mem[wp_q] <= '{vol: vol_q, prod: prod_q, quot: quot_w};
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ma_q <= MaPeriodReset;
      lb_q <= LookBackReset;
      wp_q <= '0;
      bars_q <= '0;
      k_q <= '0;
      vol_q <= '0;
      hi_q <= '0;
      lo_q <= '0;
      cl_q <= '0;
      range_q <= '0;
      rem_q <= '0;
      dsr_q <= '0;
      prod_q <= '0;
      maxp_q <= '0;
      quot_q <= '0;
      maxq_q <= '0;
      dvd_q <= '0;
      lowest_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      class_q <= '0;
      avg_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MA_PERIOD: ma_q <= cfg_data_i;
          REG_LOOK_BACK: lb_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            vol_q <= bar_volume_i;
            hi_q <= high_price_i;
            lo_q <= low_price_i;
            cl_q <= close_price_i;
            range_q <= (high_price_i >= low_price_i) ? high_price_i - low_price_i : '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q <= ProdWidth'(vol_q) * ProdWidth'(range_q);
          dvd_q <= {vol_q, {FracBits{1'b0}}};
          dsr_q <= range_q;
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= ST_DIVQ;
        end
        ST_DIVQ: begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + DCW'(1);
          if (cnt_q == DCW'(DivSteps - 1)) state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          quot_q <= quot_w;
          if (bars_q < DepthC) bars_q <= bars_q + CW'(1);
          k_q <= '0;
          sum_q <= '0;
          maxp_q <= '0;
          maxq_q <= '0;
          lowest_q <= '1;
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (k_q < n_ma) sum_q <= sum_q + SW'(e_vol);
          if (k_q < n_lb) begin
            if (e_prod > maxp_q) maxp_q <= e_prod;
            if ((e_prod != '0) && (e_quot > maxq_q)) maxq_q <= e_quot;
          end
          if ((k_q < LowN) && (e_vol < lowest_q)) lowest_q <= e_vol;
          if (k_q + CW'(1) == n_walk) begin
            state_q <= ST_SETUP;
          end else begin
            k_q <= k_q + CW'(1);
            state_q <= ST_READ;
          end
        end
        ST_SETUP: begin
          dvd_q <= QuotWidth'(sum_q);
          dsr_q <= DataWidth'(n_ma);
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= ST_DIVA;
        end
        ST_DIVA: begin
          dvd_q <= dvd_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + DCW'(1);
          if (cnt_q == DCW'(DivSteps - 1)) begin
            avg_q <= dvd_d[DataWidth-1:0];
            class_q <= cls;
            out_valid_q <= 1'b1;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign bar_class_o      = class_q;
  assign class_volume_o   = vol_q;
  assign average_volume_o = avg_q;

endmodule

@@ rtl/core/vbc_checker.sv @@
// checker: port-level assertions for the volume bar classifier, with its bind
module vbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [vbc_pkg::ClassWidth-1:0]  bar_class_o,
  input logic [vbc_pkg::DataWidth-1:0]   class_volume_o,
  input logic [vbc_pkg::DataWidth-1:0]   average_volume_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bar_class_o)
      && $stable(class_volume_o) && $stable(average_volume_o))
    else $error("stalled result changed");

  // no new request while a result waits
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // a taken result is not repeated
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

  // accepted request is followed by a busy period
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("block not busy after request");

endmodule

bind volume_bar_classifier vbc_checker u_vbc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .bar_class_o      (bar_class_o),
  .class_volume_o   (class_volume_o),
  .average_volume_o (average_volume_o)
);
